// File: rtl/ows_pkg.sv
package ows_pkg;

  // default number of records held
  localparam int unsigned DepthDefault = 8;

  // command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // result status codes
  localparam logic [1:0] STATUS_RECORD  = 2'd0;
  localparam logic [1:0] STATUS_EVICTED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  // one stored record
  typedef struct packed {
    logic [63:0]        name_tag;
    logic [7:0]         kind;
    logic signed [31:0] amount;
  } record_t;

  // one result item
  typedef struct packed {
    logic [1:0] status;
    record_t    rec;
  } result_t;

  // shift controls shared by every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// File: rtl/ows_cell.sv
module ows_cell
  import ows_pkg::*;
(
  input  logic    clk,
  input  shift_t  shift,
  input  record_t above,
  input  record_t below,
  output record_t entry
);

  // push moves records one cell towards the bottom, pop one towards the top
  always_ff @(posedge clk) begin
    if (shift.push) begin
      entry <= above;
    end else if (shift.pop) begin
      entry <= below;
    end
  end

endmodule

// File: rtl/ows_out_buf.sv
module ows_out_buf
  import ows_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    buf_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;

  assign buf_ready = !skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (res_valid) begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_res    <= skid_res;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
      if (res_valid) begin
        out_res <= res;
      end
    end
  end

  // a result is never offered while the skid entry is occupied
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> !res_valid)
    else $error("result offered while skid entry full");

  // the skid entry only fills behind a stalled output
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full with output register empty");

  // a stalled output keeps its result
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

endmodule

// File: rtl/overwrite_oldest_stack_core.sv
// Bounded last-in-first-out stack of records that drops its oldest record
// when a push arrives on a full stack.
// Input channel: in_valid/in_ready carry cmd (push, pop, peek, clear) with
// name_tag, kind and amount used by push only.
// Output channel: out_valid/out_ready carry status, out_name, out_kind and
// out_amount. Pop and peek always give one result (a record, or empty status
// with zero fields); a push onto a full stack gives the evicted bottom record;
// other pushes and clear give none.
// The records sit in a row of DEPTH cells, the top in the first cell; every
// cell loads from its neighbour in the same cycle, so one command is taken
// per cycle while in_ready is high; each result is registered before output.
// A result register plus one skid entry let commands keep flowing through a
// receiver stall until the skid entry fills; in_ready drops while it is occupied.
// Reset empties the stack and the output side; record contents are left as
// they were and are never read before a push writes them.
module overwrite_oldest_stack_core
  import ows_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic [63:0]        name_tag,
  input  logic [7:0]         kind,
  input  logic signed [31:0] amount,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [63:0]        out_name,
  output logic [7:0]         out_kind,
  output logic signed [31:0] out_amount
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic          accept;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] fill_count_next;
  logic          is_full;
  logic          is_empty;
  shift_t        shift;
  record_t       new_rec;
  record_t       cells [DEPTH];
  logic          res_valid;
  result_t       res;
  result_t       out_res;

  assign accept   = in_valid && in_ready;
  assign is_full  = (fill_count == CW'(DEPTH));
  assign is_empty = (fill_count == '0);

  assign new_rec.name_tag = name_tag;
  assign new_rec.kind     = kind;
  assign new_rec.amount   = amount;

  // shift controls for the cell row
  assign shift.push = accept && (cmd == CMD_PUSH);
  assign shift.pop  = accept && (cmd == CMD_POP) && !is_empty;

  // row of record cells, top first
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    record_t above;
    record_t below;
    if (i == 0) begin : g_top
      assign above = new_rec;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_bottom
      assign below = cells[i];
    end else begin : g_upper
      assign below = cells[i+1];
    end
    ows_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .above (above),
      .below (below),
      .entry (cells[i])
    );
  end

  // fill count
  always_comb begin
    fill_count_next = fill_count;
    if (accept) begin
      case (cmd)
        CMD_PUSH:  if (!is_full) fill_count_next = fill_count + CW'(1);
        CMD_POP:   if (!is_empty) fill_count_next = fill_count - CW'(1);
        CMD_CLEAR: fill_count_next = '0;
        default:   fill_count_next = fill_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  // result of the accepted command
  always_comb begin
    res_valid  = 1'b0;
    res.status = STATUS_RECORD;
    res.rec    = cells[0];
    case (cmd)
      CMD_PUSH: begin
        res_valid  = accept && is_full;
        res.status = STATUS_EVICTED;
        res.rec    = cells[DEPTH-1];
      end
      CMD_POP, CMD_PEEK: begin
        res_valid = accept;
        if (is_empty) begin
          res.status = STATUS_EMPTY;
          res.rec    = '0;
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  ows_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .buf_ready (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status     = out_res.status;
  assign out_name   = out_res.rec.name_tag;
  assign out_kind   = out_res.rec.kind;
  assign out_amount = out_res.rec.amount;

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (rst) fill_count <= CW'(DEPTH))
    else $error("fill count above depth");

  // push onto a stack with room grows it by one
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_PUSH && !is_full) |=> fill_count == $past(fill_count) + CW'(1))
    else $error("push did not grow the stack");

  // pop of a non-empty stack shrinks it by one
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_POP && !is_empty) |=> fill_count == $past(fill_count) - CW'(1))
    else $error("pop did not shrink the stack");

  // clear empties the stack
  assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_CLEAR) |=> is_empty)
    else $error("clear left records behind");

endmodule
